@@ rtl/cwwp_pkg.sv @@
package cwwp_pkg;

    localparam int DEGREE_W      = 24;
    localparam int WORD_W        = 32;
    localparam int ADDR_OUT_W    = 24;
    localparam int BASE_W        = 28;
    localparam int PAD_W         = 4;
    // wide enough for a lane index at the largest lane count (eight)
    localparam int LANE_IDX_BITS = 3;
    // degree + LANES - 1 stays below 2^25; three more bits make the reciprocal exact
    localparam int DIV_SHIFT     = 28;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [WORD_W-1:0] PAD_WORD = 32'hffff_ffff;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_EDGE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef enum logic [1:0] {
        OP_ERROR,
        OP_VERTEX,
        OP_EDGE
    } op_t;

    typedef struct packed {
        logic                mode;
        logic [DEGREE_W-1:0] degree;
        logic [WORD_W-1:0]   edge_word;
    } in_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [WORD_W-1:0]     lane_zero;
        logic [WORD_W-1:0]     lane_one;
        logic [WORD_W-1:0]     lane_two;
        logic [WORD_W-1:0]     lane_three;
        logic [ADDR_OUT_W-1:0] word_address;
    } out_t;

    // one classified item handed from the front to the back
    typedef struct packed {
        op_t                      op;
        logic [LANE_IDX_BITS-1:0] lane;
        logic                     last;
        logic [WORD_W-1:0]        word;
        logic [DEGREE_W-1:0]      nwords;
        logic [PAD_W-1:0]         deg_lo;
    } entry_t;

endpackage

@@ rtl/cwwp_queue.sv @@
module cwwp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cwwp_pkg::entry_t  push_data,
    output logic              push_ready,
    input  logic              pop,
    output logic              pop_valid,
    output cwwp_pkg::entry_t  pop_data
);

    localparam int DEPTH = cwwp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cwwp_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/cwwp_front.sv @@
module cwwp_front #(
    parameter int LANES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cwwp_pkg::in_t     s_data,
    output logic              push,
    output cwwp_pkg::entry_t  push_data,
    input  logic              push_ready
);

    localparam int IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int DIV_IN_W = cwwp_pkg::DEGREE_W + 1;
    localparam int PROD_W = DIV_IN_W + cwwp_pkg::DIV_SHIFT;
    localparam logic [IDX_W-1:0] LAST_LANE = IDX_W'(LANES - 1);
    // ceil(2^DIV_SHIFT / LANES)
    localparam logic [cwwp_pkg::DIV_SHIFT-1:0] RECIP =
        cwwp_pkg::DIV_SHIFT'(((64'd1 << cwwp_pkg::DIV_SHIFT) + LANES - 1) / LANES);

    logic [cwwp_pkg::DEGREE_W-1:0] owed_reg, owed_next;
    logic [IDX_W-1:0]              vfill_reg, vfill_next;
    logic [IDX_W-1:0]              efill_reg, efill_next;
    logic [DIV_IN_W-1:0]           div_in;
    logic [PROD_W-1:0]             prod;
    logic                          accept;
    logic                          flush;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;
    assign push    = accept;

    // ceil(degree / LANES) by reciprocal multiply, exact over the whole degree range
    assign div_in = DIV_IN_W'(s_data.degree) + DIV_IN_W'(LANES - 1);
    assign prod   = PROD_W'(div_in) * PROD_W'(RECIP);
    assign flush  = (efill_reg == LAST_LANE) || (owed_reg == cwwp_pkg::DEGREE_W'(1));

    always_comb begin
        owed_next        = owed_reg;
        vfill_next       = vfill_reg;
        efill_next       = efill_reg;
        push_data.op     = cwwp_pkg::OP_ERROR;
        push_data.lane   = '0;
        push_data.last   = 1'b0;
        push_data.word   = s_data.edge_word;
        push_data.nwords = prod[cwwp_pkg::DIV_SHIFT +: cwwp_pkg::DEGREE_W];
        push_data.deg_lo = s_data.degree[cwwp_pkg::PAD_W-1:0];
        if (!s_data.mode) begin
            if (owed_reg == '0) begin
                push_data.op   = cwwp_pkg::OP_VERTEX;
                push_data.lane = cwwp_pkg::LANE_IDX_BITS'(vfill_reg);
                push_data.last = (vfill_reg == LAST_LANE);
                if (accept) begin
                    owed_next  = s_data.degree;
                    vfill_next = (vfill_reg == LAST_LANE) ? '0 : vfill_reg + 1'b1;
                end
            end
        end else begin
            if (owed_reg != '0) begin
                push_data.op   = cwwp_pkg::OP_EDGE;
                push_data.lane = cwwp_pkg::LANE_IDX_BITS'(efill_reg);
                push_data.last = flush;
                if (accept) begin
                    owed_next  = owed_reg - 1'b1;
                    efill_next = flush ? '0 : efill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg  <= '0;
            vfill_reg <= '0;
            efill_reg <= '0;
        end else begin
            owed_reg  <= owed_next;
            vfill_reg <= vfill_next;
            efill_reg <= efill_next;
        end
    end

endmodule

@@ rtl/cwwp_back.sv @@
module cwwp_back #(
    parameter int LANES      = 4,
    parameter int ADDR_WIDTH = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    input  cwwp_pkg::entry_t  pop_data,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output cwwp_pkg::out_t    m_data
);

    localparam int W = cwwp_pkg::WORD_W;
    localparam int STORED = LANES - 1;
    localparam logic [cwwp_pkg::PAD_W-1:0] LANES_PAD = cwwp_pkg::PAD_W'(LANES);

    logic [W-1:0] vst_reg [STORED];
    logic [W-1:0] est_reg [STORED];
    logic [W-1:0] vout [4];
    logic [W-1:0] eout [4];

    logic [cwwp_pkg::BASE_W-1:0] base_reg, base_next;
    logic [ADDR_WIDTH-1:0]       vcount_reg, vcount_next;
    logic [ADDR_WIDTH-1:0]       ecount_reg, ecount_next;
    logic [cwwp_pkg::ADDR_OUT_W-1:0] vaddr, eaddr;
    logic                        m_valid_reg, m_valid_next;
    cwwp_pkg::out_t              m_data_reg, m_data_next;
    logic [cwwp_pkg::PAD_W-1:0]  pad;
    logic [W-1:0]                ventry;
    logic                        m_load;

    assign pop     = pop_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign pad    = pop_data.nwords[cwwp_pkg::PAD_W-1:0] * LANES_PAD - pop_data.deg_lo;
    assign ventry = {pad, base_reg};

    generate
        if (ADDR_WIDTH >= cwwp_pkg::ADDR_OUT_W) begin : g_addr_cut
            assign vaddr = vcount_reg[cwwp_pkg::ADDR_OUT_W-1:0];
            assign eaddr = ecount_reg[cwwp_pkg::ADDR_OUT_W-1:0];
        end else begin : g_addr_ext
            assign vaddr = cwwp_pkg::ADDR_OUT_W'(vcount_reg);
            assign eaddr = cwwp_pkg::ADDR_OUT_W'(ecount_reg);
        end
    endgenerate

    // visible lanes: earlier lanes from storage, the current one from the item,
    // edge lanes past the current one padded
    genvar j;
    generate
        for (j = 0; j < 4; j++) begin : g_lane
            if (j < STORED) begin : g_stored
                assign vout[j] = vst_reg[j];
                assign eout[j] = (pop_data.lane > cwwp_pkg::LANE_IDX_BITS'(j)) ? est_reg[j] :
                                 (pop_data.lane == cwwp_pkg::LANE_IDX_BITS'(j)) ? pop_data.word :
                                 cwwp_pkg::PAD_WORD;
            end else if (j == STORED) begin : g_top
                assign vout[j] = ventry;
                assign eout[j] = (pop_data.lane == cwwp_pkg::LANE_IDX_BITS'(j)) ?
                                 pop_data.word : cwwp_pkg::PAD_WORD;
            end else begin : g_absent
                assign vout[j] = '0;
                assign eout[j] = cwwp_pkg::PAD_WORD;
            end
        end
    endgenerate

    always_comb begin
        base_next   = base_reg;
        vcount_next = vcount_reg;
        ecount_next = ecount_reg;
        m_load      = 1'b0;
        m_data_next = '0;
        if (pop) begin
            unique case (pop_data.op)
                cwwp_pkg::OP_VERTEX: begin
                    base_next = base_reg + cwwp_pkg::BASE_W'(pop_data.nwords);
                    if (pop_data.last) begin
                        m_load                   = 1'b1;
                        m_data_next.kind         = cwwp_pkg::KIND_VERTEX;
                        m_data_next.lane_zero    = vout[0];
                        m_data_next.lane_one     = vout[1];
                        m_data_next.lane_two     = vout[2];
                        m_data_next.lane_three   = vout[3];
                        m_data_next.word_address = vaddr;
                        vcount_next              = vcount_reg + 1'b1;
                    end
                end
                cwwp_pkg::OP_EDGE: begin
                    if (pop_data.last) begin
                        m_load                   = 1'b1;
                        m_data_next.kind         = cwwp_pkg::KIND_EDGE;
                        m_data_next.lane_zero    = eout[0];
                        m_data_next.lane_one     = eout[1];
                        m_data_next.lane_two     = eout[2];
                        m_data_next.lane_three   = eout[3];
                        m_data_next.word_address = eaddr;
                        ecount_next              = ecount_reg + 1'b1;
                    end
                end
                default: begin
                    m_load           = 1'b1;
                    m_data_next.kind = cwwp_pkg::KIND_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            vcount_reg  <= '0;
            ecount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            base_reg    <= base_next;
            vcount_reg  <= vcount_next;
            ecount_reg  <= ecount_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_data_reg <= m_data_next;
        end
        for (int k = 0; k < STORED; k++) begin
            if (pop && pop_data.lane == cwwp_pkg::LANE_IDX_BITS'(k)) begin
                if (pop_data.op == cwwp_pkg::OP_VERTEX) begin
                    vst_reg[k] <= ventry;
                end
                if (pop_data.op == cwwp_pkg::OP_EDGE) begin
                    est_reg[k] <= pop_data.word;
                end
            end
        end
    end

endmodule

@@ rtl/csr_wide_word_packer_unit.sv @@
// CSR wide-word packer. Takes one item per cycle, sustained, as long as results
// are taken: the front checks each item against the edges still owed and tracks
// lane fill in its own registers, and the back assembles words and advances the
// base address, also one item per cycle. Between them sits a two-entry queue, and
// the result leaves through an output register, so an item's result appears only
// after it has passed the queue and then the output register. Vertex headers and
// edge words that only fill a lane produce no result; a completed word or a
// protocol error produces exactly one. No clearing pass after reset.
module csr_wide_word_packer_unit #(
    parameter int LANES      = 4,
    parameter int ADDR_WIDTH = 24
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  cwwp_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output cwwp_pkg::out_t  m_data
);

    logic              q_push, q_push_ready, q_pop, q_pop_valid;
    cwwp_pkg::entry_t  q_push_data, q_pop_data;

    cwwp_front #(
        .LANES(LANES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (q_push),
        .push_data (q_push_data),
        .push_ready(q_push_ready)
    );

    cwwp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .push_ready(q_push_ready),
        .pop       (q_pop),
        .pop_valid (q_pop_valid),
        .pop_data  (q_pop_data)
    );

    cwwp_back #(
        .LANES     (LANES),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(q_pop_valid),
        .pop_data (q_pop_data),
        .pop      (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind == cwwp_pkg::KIND_VERTEX ||
                     m_data.kind == cwwp_pkg::KIND_EDGE ||
                     m_data.kind == cwwp_pkg::KIND_ERROR))
        else $error("illegal result kind");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == cwwp_pkg::KIND_ERROR) |->
        (m_data.lane_zero == '0 && m_data.lane_one == '0 && m_data.lane_two == '0 &&
         m_data.lane_three == '0 && m_data.word_address == '0))
        else $error("error result carries data");

    a_error_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_push_ready && q_push_data.op == cwwp_pkg::OP_ERROR) |->
        (s_valid && s_ready))
        else $error("error item queued without an accepted input");

    a_queue_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop_valid && !m_valid) |-> q_pop)
        else $error("back stalled with output free");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import cwwp_pkg::*;

    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_EDGE   = 1'b1;
    localparam int   PACK_LANES  = 4;
    localparam int   TAIL_ITEMS  = 250;   // no idling once this few items remain
    localparam int   HOLD_AT     = 600;   // accepted items before the long result stall
    localparam int   HOLD_CYCLES = 400;
    localparam int   DRAIN_AT    = 1200;  // random item that waits for all results first

    typedef struct {
        in_t item;
        bit  drain;
    } pending_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    csr_wide_word_packer_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // packer shadow state
    logic [BASE_W-1:0]     base_word;
    logic [WORD_W-1:0]     vtx_lanes [PACK_LANES];
    int                    vtx_fill;
    logic [WORD_W-1:0]     edge_lanes [PACK_LANES];
    int                    edge_fill;
    logic [DEGREE_W-1:0]   edges_left;
    logic [ADDR_OUT_W-1:0] vtx_words;
    logic [ADDR_OUT_W-1:0] edge_words;

    pending_t pending_items [$];
    out_t     packed_words_due [$];
    int       total_items = 0;
    int       mismatches = 0;

    logic feed_done = 1'b0;
    logic all_done = 1'b1;
    logic rx_holding = 1'b0;

    task automatic pack_item(input in_t it);
        out_t                w;
        logic [DEGREE_W:0]   nwords;
        logic [DEGREE_W+2:0] padded;
        logic [PAD_W-1:0]    pad;
        w = '0;
        if (it.mode == MODE_VERTEX) begin
            if (edges_left != 0) begin
                w.kind = KIND_ERROR;
                packed_words_due = {packed_words_due, w};
            end else begin
                nwords = (DEGREE_W+1)'(({1'b0, it.degree} + (PACK_LANES - 1)) / PACK_LANES);
                padded = (DEGREE_W+3)'(nwords * PACK_LANES);
                pad = PAD_W'(padded - it.degree);
                vtx_lanes[vtx_fill] = {pad, base_word};
                base_word = base_word + BASE_W'(nwords);
                edges_left = it.degree;
                vtx_fill++;
                if (vtx_fill == PACK_LANES) begin
                    w.kind = KIND_VERTEX;
                    w.lane_zero = vtx_lanes[0];
                    w.lane_one = vtx_lanes[1];
                    w.lane_two = vtx_lanes[2];
                    w.lane_three = vtx_lanes[3];
                    w.word_address = vtx_words;
                    packed_words_due = {packed_words_due, w};
                    vtx_words++;
                    vtx_fill = 0;
                end
            end
        end else begin
            if (edges_left == 0) begin
                w.kind = KIND_ERROR;
                packed_words_due = {packed_words_due, w};
            end else begin
                edge_lanes[edge_fill] = it.edge_word;
                edge_fill++;
                edges_left--;
                if (edge_fill == PACK_LANES || edges_left == 0) begin
                    for (int l = edge_fill; l < PACK_LANES; l++) edge_lanes[l] = PAD_WORD;
                    w.kind = KIND_EDGE;
                    w.lane_zero = edge_lanes[0];
                    w.lane_one = edge_lanes[1];
                    w.lane_two = edge_lanes[2];
                    w.lane_three = edge_lanes[3];
                    w.word_address = edge_words;
                    packed_words_due = {packed_words_due, w};
                    edge_words++;
                    edge_fill = 0;
                end
            end
        end
    endtask

    task automatic note_fail(input string why, input out_t want, input out_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: want kind=%0d lanes=%h %h %h %h addr=%h", why, want.kind,
                     want.lane_zero, want.lane_one, want.lane_two, want.lane_three,
                     want.word_address);
            $display("%s:  got kind=%0d lanes=%h %h %h %h addr=%h", why, got.kind,
                     got.lane_zero, got.lane_one, got.lane_two, got.lane_three,
                     got.word_address);
        end
    endtask

    task automatic add_item(input logic mode, input logic [DEGREE_W-1:0] deg,
                            input logic [WORD_W-1:0] word, input bit drain);
        pending_t p;
        p.item.mode = mode;
        p.item.degree = deg;
        p.item.edge_word = word;
        p.drain = drain;
        pending_items = {pending_items, p};
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PAD_WORD;
            default: return $urandom;
        endcase
    endfunction

    task automatic build_stimulus();
        int owed;
        int deg;
        int r;
        bit drain;
        // edge before any vertex, then a zero-degree vertex
        add_item(MODE_EDGE, '1, PAD_WORD, 0);
        add_item(MODE_VERTEX, 24'd0, PAD_WORD, 0);
        // single edge: partial word padded out
        add_item(MODE_VERTEX, 24'd1, '0, 0);
        add_item(MODE_EDGE, '0, '0, 0);
        // exactly one full word
        add_item(MODE_VERTEX, 24'd4, $urandom, 0);
        add_item(MODE_EDGE, DEGREE_W'($urandom), PAD_WORD, 0);
        add_item(MODE_EDGE, DEGREE_W'($urandom), '0, 0);
        add_item(MODE_EDGE, DEGREE_W'($urandom), 32'ha5a5_a5a5, 0);
        add_item(MODE_EDGE, DEGREE_W'($urandom), 32'h5a5a_5a5a, 0);
        // vertex arriving while edges owed, then one edge too many
        add_item(MODE_VERTEX, 24'd5, $urandom, 0);
        add_item(MODE_VERTEX, '1, '1, 0);
        for (int i = 0; i < 5; i++) add_item(MODE_EDGE, DEGREE_W'($urandom), $urandom, 0);
        add_item(MODE_EDGE, '0, $urandom, 0);
        add_item(MODE_VERTEX, 24'd3, $urandom, 0);
        for (int i = 0; i < 3; i++) add_item(MODE_EDGE, DEGREE_W'($urandom), $urandom, 0);
        add_item(MODE_VERTEX, 24'd2, $urandom, 0);
        for (int i = 0; i < 2; i++) add_item(MODE_EDGE, DEGREE_W'($urandom), $urandom, 0);

        // mostly well-formed vertex/edge runs, some protocol noise
        owed = 0;
        for (int i = 0; i < 2000; i++) begin
            drain = (i == DRAIN_AT);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                if (owed == 0) add_item(MODE_EDGE, DEGREE_W'($urandom), pick_word(), drain);
                else add_item(MODE_VERTEX, DEGREE_W'($urandom), $urandom, drain);
            end else if (owed == 0) begin
                r = $urandom_range(0, 99);
                if (r < 70) deg = $urandom_range(0, 8);
                else if (r < 95) deg = $urandom_range(9, 40);
                else deg = $urandom_range(41, 120);
                add_item(MODE_VERTEX, DEGREE_W'(deg), $urandom, drain);
                owed = deg;
            end else begin
                add_item(MODE_EDGE, DEGREE_W'($urandom), pick_word(), drain);
                owed--;
            end
        end
        while (owed > 0) begin
            add_item(MODE_EDGE, DEGREE_W'($urandom), pick_word(), 0);
            owed--;
        end
        // largest degree last: it can never be paid off within the run
        add_item(MODE_VERTEX, '1, $urandom, 0);
        for (int i = 0; i < 6; i++) add_item(MODE_EDGE, DEGREE_W'($urandom), pick_word(), 0);
        add_item(MODE_VERTEX, DEGREE_W'($urandom), $urandom, 0);
    endtask

    // sender
    int tx_gap = 0;
    int tx_cycle = 0;
    bit drain_armed = 0;

    always @(posedge aclk) begin
        logic     next_valid;
        in_t      next_data;
        pending_t head;
        bit       calm;
        next_valid = s_valid;
        next_data = s_data;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            tx_cycle++;
            calm = ((tx_cycle / 250) % 4) == 3;
            if (!s_valid || s_ready) begin
                next_valid = 1'b0;
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_items.size() > 0) begin
                    head = pending_items[0];
                    if (head.drain && !drain_armed) begin
                        // drop valid once so the last acceptance shows in all_done
                        drain_armed = 1;
                    end else if (drain_armed && !all_done) begin
                        // hold until every result is back
                    end else if (!calm && !rx_holding && pending_items.size() > TAIL_ITEMS
                                 && $urandom_range(0, 7) == 0) begin
                        tx_gap = $urandom_range(0, 8);
                    end else begin
                        void'(pending_items.pop_front());
                        next_valid = 1'b1;
                        next_data = head.item;
                        drain_armed = 0;
                    end
                end
            end
        end
        feed_done <= (pending_items.size() == 0) && !next_valid;
        s_valid <= next_valid;
        s_data <= next_data;
    end

    // receiver, prediction and checking
    int items_in = 0;
    int rx_gap = 0;
    int rx_cycle = 0;
    int hold_left = 0;
    bit hold_done = 0;

    always @(posedge aclk) begin
        out_t want;
        logic rdy;
        bit   calm;
        rdy = 1'b0;
        if (aresetn) begin
            rx_cycle++;
            calm = ((rx_cycle / 300) % 3) == 2;
            if (s_valid && s_ready) begin
                pack_item(s_data);
                items_in++;
            end
            if (m_valid && m_ready) begin
                if (packed_words_due.size() == 0) begin
                    note_fail("unexpected item", '0, m_data);
                end else begin
                    want = packed_words_due.pop_front();
                    if (m_data.kind !== want.kind || m_data.lane_zero !== want.lane_zero ||
                        m_data.lane_one !== want.lane_one ||
                        m_data.lane_two !== want.lane_two ||
                        m_data.lane_three !== want.lane_three ||
                        m_data.word_address !== want.word_address)
                        note_fail("mismatch", want, m_data);
                end
            end
            if (items_in >= HOLD_AT && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (rx_gap > 0) begin
                rx_gap--;
            end else if (!calm && items_in + TAIL_ITEMS < total_items
                         && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(0, 8);
            end else begin
                rdy = 1'b1;
            end
        end
        m_ready <= rdy;
        rx_holding <= (hold_left > 0);
        all_done <= (packed_words_due.size() == 0);
    end

    initial begin
        #1_000_000;
        $display("csr_wide_word_packer_unit: mismatch");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        base_word = '0;
        vtx_fill = 0;
        edge_fill = 0;
        edges_left = '0;
        vtx_words = '0;
        edge_words = '0;
        for (int l = 0; l < PACK_LANES; l++) begin
            vtx_lanes[l] = '0;
            edge_lanes[l] = '0;
        end
        build_stimulus();
        total_items = pending_items.size();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (!(feed_done && all_done));
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (!all_done) mismatches++;
        if (mismatches == 0) begin
            $display("csr_wide_word_packer_unit: match");
        end else begin
            $display("csr_wide_word_packer_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cwwp_pkg.sv
rtl/cwwp_queue.sv
rtl/cwwp_front.sv
rtl/cwwp_back.sv
rtl/csr_wide_word_packer_unit.sv
verif/testbench.sv
